@@ rtl/bounded_list_engine_core_macros.svh @@
// Assertion macros for the bounded list engine
`ifndef BOUNDED_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_LIST_ENGINE_CORE_MACROS_SVH
// property holds in the cycle it is sampled
`define BLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the following cycle
`define BLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/ble_pkg.sv @@
// Package: capacity, opcodes, status codes and the cell control struct
package ble_pkg;
  localparam int CAPACITY = 32;
  localparam int CW       = $clog2(CAPACITY + 1);

  localparam logic [3:0] OP_PUSH   = 4'd0;
  localparam logic [3:0] OP_APPEND = 4'd1;
  localparam logic [3:0] OP_INSERT = 4'd2;
  localparam logic [3:0] OP_POP    = 4'd3;
  localparam logic [3:0] OP_READ   = 4'd4;
  localparam logic [3:0] OP_DELETE = 4'd5;
  localparam logic [3:0] OP_DEDUP  = 4'd6;
  localparam logic [3:0] OP_SORT   = 4'd7;
  localparam logic [3:0] OP_CLEAR  = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic        shr;      // open gap: cells at index > at take left neighbour
    logic        shl;      // close gap: cells at index >= at take right neighbour
    logic        ins;      // cell at index == at loads value
    logic        swap;     // odd-even sort phase active
    logic        odd;      // phase parity
    logic [CW-1:0] at;
    logic [31:0] value;
  } cell_ctl_t;
endpackage

@@ rtl/ble_cell.sv @@
// One storage cell of the list chain
module ble_cell (
  input  logic              clk,
  input  ble_pkg::cell_ctl_t ctl,
  input  logic [ble_pkg::CW-1:0] idx,
  input  logic [31:0]       left_q,
  input  logic [31:0]       right_q,
  input  logic              left_ok,   // left neighbour exists and this cell is inside the list
  input  logic              right_ok,
  output logic [31:0]       q
);
  import ble_pkg::*;
  logic [31:0] q_r, q_nxt;
  logic        first;   // this cell is the lower one of its sort pair
  assign first = (idx[0] == ctl.odd);
  always_comb begin
    q_nxt = q_r;
    if (ctl.ins && idx == ctl.at) q_nxt = ctl.value;
    else if (ctl.shr && idx > ctl.at) q_nxt = left_q;
    else if (ctl.shl && idx >= ctl.at) q_nxt = right_q;
    else if (ctl.swap) begin
      if (first && right_ok && $signed(q_r) > $signed(right_q)) q_nxt = right_q;
      else if (!first && left_ok && $signed(left_q) > $signed(q_r)) q_nxt = left_q;
    end
  end
  always_ff @(posedge clk) q_r <= q_nxt;
  assign q = q_r;
endmodule

@@ rtl/bounded_list_engine_core.sv @@
// Top level of the bounded list engine: sequencer around a chain of cells
// Usage:
//  Input channel in_valid/in_stall carries one request: in_opcode,
//  in_data_value, in_position. Result channel out_valid/out_stall returns
//  result_value, status and length for every request, in order.
//  A request is taken only while the engine is idle and no result waits.
//  Path from accept to result: push, append, pop, delete, clear and every
//  error pass through the done state only; read fetches the cell first.
//  Ordered insert scans one cell a cycle past the smaller entries.
//  Sort runs odd-even transposition over the cell row, CAPACITY phases.
//  Dedup checks one pair a cycle, closing gaps in place.
//  One request is in flight at a time; the next can be taken once the
//  result is accepted.
//  Reset (rst_n low, synchronous) empties the list; cell contents are
//  not cleared and never read past length.
//  While out_stall is high the result holds and new requests wait.
module bounded_list_engine_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [3:0]             in_opcode,
  input  logic signed [31:0]     in_data_value,
  input  logic [6:0]             in_position,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_result_value,
  output logic [1:0]             out_status,
  output logic [6:0]             out_length
);
  import ble_pkg::*;
  `include "bounded_list_engine_core_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0, S_SEARCH = 3'd1, S_SORT = 3'd2,
                         S_DEDUP = 3'd3, S_DONE = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;      // list length
  logic [CW-1:0] ptr_r, ptr_nxt;      // scan pointer / sort phase count
  logic [31:0]   val_r, val_nxt;
  logic [31:0]   res_r, res_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          ov_r, ov_nxt;
  logic          rd_r, rd_nxt;        // search state is serving a read
  cell_ctl_t     ctl;
  logic [31:0]   q [CAPACITY];
  logic [31:0]   sel_q;               // cell at ptr
  logic [31:0]   prev_q;              // cell at ptr-1
  logic [CW-1:0] pm1;

  assign pm1 = ptr_r - CW'(1);
  always_comb begin
    sel_q = '0;
    prev_q = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ptr_r == CW'(i)) sel_q = q[i];
      if (pm1 == CW'(i)) prev_q = q[i];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ble_cell u_cell (
      .clk(clk), .ctl(ctl), .idx(CW'(g)),
      .left_q(g == 0 ? 32'd0 : q[(g == 0) ? 0 : g-1]),
      .right_q(g == CAPACITY-1 ? 32'd0 : q[(g == CAPACITY-1) ? g : g+1]),
      .left_ok((g != 0) && (CW'(g) < cnt_r)),
      .right_ok((g != CAPACITY-1) && (CW'(g+1) < cnt_r)),
      .q(q[g])
    );
  end

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_result_value = res_r;
  assign out_status = st_r;
  assign out_length = 7'(cnt_r);

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ptr_nxt = ptr_r; val_nxt = val_r;
    res_nxt = res_r; st_nxt = st_r; ov_nxt = ov_r; rd_nxt = 1'b0;
    ctl = '0; ctl.value = val_r; ctl.at = ptr_r; ctl.odd = ptr_r[0];
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        res_nxt = '0; st_nxt = ST_OK; val_nxt = in_data_value; ptr_nxt = '0;
        state_nxt = S_DONE;
        case (in_opcode)
          OP_PUSH, OP_APPEND, OP_INSERT:
            if (cnt_r >= CW'(CAPACITY)) st_nxt = ST_FULL;
            else if (in_opcode == OP_INSERT) state_nxt = S_SEARCH;
            else begin
              ctl.shr = 1'b1; ctl.ins = 1'b1; ctl.value = in_data_value;
              ctl.at = (in_opcode == OP_PUSH) ? '0 : cnt_r;
              cnt_nxt = cnt_r + CW'(1);
            end
          OP_POP:
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else begin
              res_nxt = q[0]; ctl.shl = 1'b1; ctl.at = '0; cnt_nxt = cnt_r - CW'(1);
            end
          OP_READ, OP_DELETE:
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else if (in_position == '0 || in_position > 7'(cnt_r)) st_nxt = ST_RANGE;
            else begin
              ptr_nxt = CW'(in_position - 7'd1);
              if (in_opcode == OP_DELETE) begin
                ctl.shl = 1'b1; ctl.at = CW'(in_position - 7'd1);
                cnt_nxt = cnt_r - CW'(1);
              end else state_nxt = S_SEARCH; // read: fetch on next cycle
            end
          OP_DEDUP: if (cnt_r > CW'(1)) begin ptr_nxt = CW'(1); state_nxt = S_DEDUP; end
          OP_SORT:  if (cnt_r > CW'(1)) state_nxt = S_SORT;
          OP_CLEAR: cnt_nxt = '0;
          default: ;
        endcase
        rd_nxt = (in_opcode == OP_READ) && (state_nxt == S_SEARCH);
      end
      S_SEARCH:
        if (rd_r) begin
          res_nxt = sel_q; state_nxt = S_DONE;
        end else if (ptr_r < cnt_r && $signed(sel_q) < $signed(val_r)) begin
          ptr_nxt = ptr_r + CW'(1);
        end else begin
          ctl.shr = 1'b1; ctl.ins = 1'b1; cnt_nxt = cnt_r + CW'(1); state_nxt = S_DONE;
        end
      S_SORT: begin
        ctl.swap = 1'b1; ptr_nxt = ptr_r + CW'(1);
        if (ptr_r == CW'(CAPACITY-1)) state_nxt = S_DONE;
      end
      S_DEDUP:
        if (ptr_r >= cnt_r) state_nxt = S_DONE;
        else if (sel_q == prev_q) begin
          ctl.shl = 1'b1; cnt_nxt = cnt_r - CW'(1);
        end else ptr_nxt = ptr_r + CW'(1);
      S_DONE: begin ov_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0; rd_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; rd_r <= rd_nxt;
    end
    ptr_r <= ptr_nxt; val_r <= val_nxt; res_r <= res_nxt; st_r <= st_nxt;
  end

  `BLE_ASSERT(a_len_bound, cnt_r <= CW'(CAPACITY), "length beyond capacity")
  `BLE_ASSERT_NEXT(a_one_result, state_r == S_DONE, out_valid, "result not raised")
  `BLE_ASSERT(a_busy_stall, (state_r == S_IDLE) || in_stall, "request taken while busy")
  `BLE_ASSERT_NEXT(a_len_step, state_r == S_IDLE && !(in_valid && !in_stall),
    $stable(cnt_r), "length moved while idle")
endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the bounded list engine core
`timescale 1ns / 1ps
module testbench;
  import ble_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 4 * CAPACITY;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] data_value;
    logic [6:0]  position;
  } list_req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  status;
    logic [6:0]  length;
  } list_rsp_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [3:0] in_opcode;
  logic signed [31:0] in_data_value;
  logic [6:0] in_position;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_result_value;
  logic [1:0] out_status;
  logic [6:0] out_length;

  // pending requests, expected responses
  list_req_t req_queue[$];
  list_rsp_t rsp_expected[$];

  // shadow copy of the list
  logic [31:0] shadow_list[CAPACITY];
  int unsigned shadow_len = 0;

  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned reqs_sent = 0;
  int unsigned rsps_seen = 0;

  // idling controls
  bit quiet_mode;       // last part of run: no gaps or stalls
  bit hold_sender;      // sender offers nothing while this is set
  bit hold_go;          // start the long receiver hold-off
  bit hold_used;        // long hold-off already run
  int unsigned long_hold; // receiver hold-off in cycles
  int unsigned send_gap;
  int unsigned stall_gap;

  bounded_list_engine_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_data_value(in_data_value),
    .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_status(out_status),
    .out_length(out_length)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // signed compare on raw patterns
  function automatic bit key_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // apply one request to the shadow list and return the response
  function automatic list_rsp_t list_apply(list_req_t r);
    list_rsp_t rsp;
    int unsigned slot;
    int unsigned k;
    int unsigned j;
    logic [31:0] v;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.opcode)
      OP_PUSH, OP_APPEND, OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          if (r.opcode == OP_PUSH) slot = 0;
          else if (r.opcode == OP_APPEND) slot = shadow_len;
          else begin
            slot = 0;
            while (slot < shadow_len && key_less(shadow_list[slot], r.data_value))
              slot++;
          end
          for (k = shadow_len; k > slot; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[slot] = r.data_value;
          shadow_len++;
        end
      end
      OP_POP, OP_READ, OP_DELETE: begin
        if (r.opcode == OP_POP) slot = 1;
        else slot = r.position;
        if (shadow_len == 0) rsp.status = ST_EMPTY;
        else if (slot == 0 || slot > shadow_len) rsp.status = ST_RANGE;
        else if (r.opcode == OP_READ) rsp.result_value = shadow_list[slot-1];
        else begin
          if (r.opcode == OP_POP) rsp.result_value = shadow_list[0];
          for (k = slot - 1; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
          shadow_len--;
        end
      end
      OP_DEDUP: begin
        if (shadow_len > 1) begin
          j = 0;
          for (k = 1; k < shadow_len; k++)
            if (shadow_list[k] != shadow_list[j]) begin
              j++;
              shadow_list[j] = shadow_list[k];
            end
          shadow_len = j + 1;
        end
      end
      OP_SORT: begin
        for (k = 1; k < shadow_len; k++) begin
          v = shadow_list[k];
          j = k;
          while (j > 0 && key_less(v, shadow_list[j-1])) begin
            shadow_list[j] = shadow_list[j-1];
            j--;
          end
          shadow_list[j] = v;
        end
      end
      OP_CLEAR: shadow_len = 0;
      default: ;
    endcase
    rsp.length = shadow_len[6:0];
    return rsp;
  endfunction

  function automatic list_req_t mk_req(logic [3:0] op, logic [31:0] v, logic [6:0] p);
    list_req_t r;
    r.opcode = op;
    r.data_value = v;
    r.position = p;
    return r;
  endfunction

  // random value drawn from a small pool now and then, so dedup finds runs
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7) - 4;
      1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $urandom;
    endcase
  endfunction

  // driver: offer requests from the queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= '0;
      in_data_value <= '0;
      in_position <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        list_rsp_t exp_rsp;
        exp_rsp = list_apply(req_queue.pop_front());
        rsp_expected.push_back(exp_rsp);
        reqs_sent++;
      end
      if (!in_valid || !in_stall) begin
        // previous request gone, decide what is offered next
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (hold_sender || req_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else begin
          // taken request already left the queue, so the head is next
          list_req_t nx;
          nx = req_queue[0];
          in_valid <= 1'b1;
          in_opcode <= nx.opcode;
          in_data_value <= nx.data_value;
          in_position <= nx.position;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles here
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      long_hold <= 300;
      hold_used <= 1'b1;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // monitor: receiver stalls and response checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rsp_expected.size() == 0) begin
          $error("unexpected response: value %0d status %0d length %0d",
                 out_result_value, out_status, out_length);
          failures++;
        end else begin
          list_rsp_t e;
          e = rsp_expected.pop_front();
          if (out_result_value !== e.result_value) begin
            $error("result_value expected %0d got %0d",
                   $signed(e.result_value), out_result_value);
            failures++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d got %0d", e.status, out_status);
            failures++;
          end
          if (out_length !== e.length) begin
            $error("length expected %0d got %0d", e.length, out_length);
            failures++;
          end
        end
        rsps_seen++;
      end
      if (long_hold > 0) begin
        out_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        stall_gap <= $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("bounded_list_engine_core verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || rsp_expected.size() != 0)
      @(posedge clk);
  endtask

  // weighted random commands; plus noise
  task automatic queue_random(int unsigned n);
    int unsigned i;
    int unsigned op;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: op = OP_PUSH;
        3, 4, 5: op = OP_APPEND;
        6, 7, 8, 9: op = OP_INSERT;
        10, 11: op = OP_POP;
        12, 13: op = OP_READ;
        14, 15: op = OP_DELETE;
        16: op = OP_DEDUP;
        17: op = OP_SORT;
        18: op = ($urandom_range(0, 5) == 0) ? OP_CLEAR : OP_READ;
        default: op = $urandom_range(0, 15);
      endcase
      req_queue.push_back(mk_req(op[3:0], rand_value(),
        ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                    : 7'($urandom_range(0, 34))));
    end
  endtask

  initial begin
    int unsigned i;
    rst_n = 1'b0;
    quiet_mode = 1'b0;
    hold_sender = 1'b1;
    hold_go = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-store errors, extremes, every command, full store
    req_queue.push_back(mk_req(OP_POP, 0, 0));
    req_queue.push_back(mk_req(OP_READ, 0, 1));
    req_queue.push_back(mk_req(OP_DELETE, 0, 1));
    req_queue.push_back(mk_req(OP_DEDUP, 0, 0));
    req_queue.push_back(mk_req(OP_SORT, 0, 0));
    req_queue.push_back(mk_req(OP_CLEAR, 0, 0));
    req_queue.push_back(mk_req(OP_APPEND, 32'h7fff_ffff, 0));
    req_queue.push_back(mk_req(OP_PUSH, 32'h8000_0000, 0));
    req_queue.push_back(mk_req(OP_INSERT, 32'hffff_ffff, 0));
    req_queue.push_back(mk_req(OP_INSERT, 32'h7fff_ffff, 0));
    req_queue.push_back(mk_req(OP_INSERT, 32'h8000_0000, 0));
    req_queue.push_back(mk_req(OP_READ, 0, 0));
    req_queue.push_back(mk_req(OP_READ, 0, 7'h7f));
    req_queue.push_back(mk_req(OP_READ, 0, 5));
    req_queue.push_back(mk_req(OP_DELETE, 0, 6));
    req_queue.push_back(mk_req(OP_DEDUP, 0, 0));
    req_queue.push_back(mk_req(OP_DELETE, 0, 2));
    req_queue.push_back(mk_req(4'hf, 32'h5555_aaaa, 7'h55));
    req_queue.push_back(mk_req(4'h9, 32'haaaa_5555, 7'h2a));
    req_queue.push_back(mk_req(OP_POP, 0, 0));
    // fill to capacity in reverse, overflow, then sort
    for (i = 0; i < CAPACITY + 1; i++)
      req_queue.push_back(mk_req(OP_PUSH, i, 0));
    req_queue.push_back(mk_req(OP_APPEND, 1, 0));
    req_queue.push_back(mk_req(OP_INSERT, 1, 0));
    req_queue.push_back(mk_req(OP_SORT, 0, 0));
    req_queue.push_back(mk_req(OP_READ, 0, 7'(CAPACITY)));
    req_queue.push_back(mk_req(OP_DELETE, 0, 7'(CAPACITY)));
    hold_sender = 1'b0;
    wait_drained();

    // receiver holds off while the sender keeps offering
    queue_random(40);
    @(posedge clk);
    hold_go = 1'b1;
    wait_drained();

    // random phases, each drained, with a sender pause between them
    for (i = 0; i < 7; i++) begin
      queue_random(200);
      wait_drained();
      hold_sender = 1'b1;
      repeat (20) @(posedge clk);
      hold_sender = 1'b0;
    end

    // last stretch without idling
    quiet_mode = 1'b1;
    queue_random(60);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d responses checked over push, append,",
             reqs_sent, rsps_seen);
    $display("ordered insert, pop, read, delete, dedup, sort, clear and unused codes");
    if (failures == 0 && rsp_expected.size() == 0) begin
      $display("bounded_list_engine_core verification clean");
    end else begin
      $display("bounded_list_engine_core verification failed");
    end
    $finish;
  end
endmodule
